>>> sv/rde_pkg.sv
// Shared types and constants for the signed radix digit emitter.
// Depends on nothing; every other file refers to it by scoped names.
package rde_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN   = 2'd2;

	// Field widths.
	localparam int NUM_W   = 32;
	localparam int SYM_W   = 8;
	localparam int BASE_W  = 5;
	localparam int DIGIT_W = 4;

	// Characters that have a fixed meaning.
	localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

	// Digit stack: radix 2 on a magnitude of 2^31 gives 32 digits.
	localparam int STACK_DEPTH = 32;
	localparam int STACK_IDX_W = 5;
	localparam int STACK_CNT_W = 6;

	// The divider retires 8 quotient bits per cycle over DIV_STEPS steps.
	localparam int DIV_BITS_PER_STEP = 8;
	localparam int DIV_STEPS         = 4;
	localparam int DIV_CNT_W         = 2;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// Status of the shared divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

>>> sv/signed_radix_digit_emitter_core.sv
// The sequencer checks the alphabet, then runs the shared divider once per digit,
// then emits one symbol per cycle when the output is free (plus one for a '-').
// A new number is accepted only in idle, once the last symbol of the previous one
// has been loaded. A bad alphabet returns the check state to idle with no output,
// and an output stall holds the sequencer in the sign or emit state.
// Reset (arst_n low, asynchronous) clears configuration, sequencer and output valid.
module signed_radix_digit_emitter_core #(
	parameter int MAX_SYMBOLS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rde_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [63:0]                        cfg_data,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [rde_pkg::NUM_W-1:0]          s_tdata,  // [31:0] number (signed)
	// Output stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [rde_pkg::SYM_W-1:0]          m_tdata,  // [7:0] symbol
	output logic                               m_tlast
);

	localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

	rde_pkg::state_t state_q, state_nxt;

	logic [MAX_SYMBOLS-1:0][rde_pkg::SYM_W-1:0] alpha_q;
	logic [rde_pkg::BASE_W-1:0]                 base_len_q;
	logic                                       neg_q;
	logic [rde_pkg::NUM_W-1:0]                  mag_q;
	logic [rde_pkg::DIGIT_W-1:0]                digit_q [rde_pkg::STACK_DEPTH];
	logic [rde_pkg::STACK_CNT_W-1:0]            sp_q;
	logic [rde_pkg::STACK_CNT_W-1:0]            sp_m1;
	logic                                       m_tvalid_q;
	logic [rde_pkg::SYM_W-1:0]                  m_tdata_q;
	logic                                       m_tlast_q;

	logic                          alpha_ok;
	logic                          accept;
	logic                          div_start;
	logic                          push;
	logic                          out_free;
	logic                          load_sign;
	logic                          load_digit;
	logic                          quo_zero;
	logic [rde_pkg::NUM_W-1:0]     div_dividend;
	logic [rde_pkg::NUM_W-1:0]     div_quo;
	logic [rde_pkg::DIGIT_W-1:0]   div_rem;
	rde_pkg::div_status_t          div_st;

	// Configuration registers; the alphabet keeps only the symbols that can be in use.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q    <= '0;
			base_len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			for (int k = 0; k < MAX_SYMBOLS; k++) begin
				if (k < 8 && cfg_index == rde_pkg::REG_ALPHA_LOW)
					alpha_q[k] <= cfg_data[(k % 8) * 8 +: 8];
				if (k >= 8 && cfg_index == rde_pkg::REG_ALPHA_HIGH)
					alpha_q[k] <= cfg_data[(k % 8) * 8 +: 8];
			end
			if (cfg_index == rde_pkg::REG_BASE_LEN)
				base_len_q <= cfg_data[rde_pkg::BASE_W-1:0];
		end
	end

	rde_alpha_chk #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_chk (
		.alpha      (alpha_q),
		.base_length(base_len_q),
		.ok         (alpha_ok)
	);

	// The divider is fed the magnitude first, then its own quotient.
	assign div_dividend = (state_q == rde_pkg::ST_CHECK) ? mag_q : div_quo;

	rde_div_unit u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (base_len_q),
		.quotient (div_quo),
		.remainder(div_rem),
		.status   (div_st)
	);

	assign quo_zero  = (div_quo == '0);
	assign out_free  = !m_tvalid_q || m_tready;
	assign sp_m1     = sp_q - 1'b1;

	// Sequencer next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rde_pkg::ST_IDLE:  if (s_tvalid) state_nxt = rde_pkg::ST_CHECK;
			rde_pkg::ST_CHECK: state_nxt = alpha_ok ? rde_pkg::ST_DIV : rde_pkg::ST_IDLE;
			rde_pkg::ST_DIV: begin
				if (div_st.done && quo_zero)
					state_nxt = neg_q ? rde_pkg::ST_SIGN : rde_pkg::ST_EMIT;
			end
			rde_pkg::ST_SIGN:  if (out_free) state_nxt = rde_pkg::ST_EMIT;
			rde_pkg::ST_EMIT: begin
				if (out_free && sp_q == rde_pkg::STACK_CNT_W'(1))
					state_nxt = rde_pkg::ST_IDLE;
			end
			default:           state_nxt = rde_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready   = 1'b0;
		div_start  = 1'b0;
		push       = 1'b0;
		load_sign  = 1'b0;
		load_digit = 1'b0;
		unique case (state_q)
			rde_pkg::ST_IDLE:  s_tready = 1'b1;
			rde_pkg::ST_CHECK: div_start = alpha_ok;
			rde_pkg::ST_DIV: begin
				push      = div_st.done;
				div_start = div_st.done && !quo_zero;
			end
			rde_pkg::ST_SIGN:  load_sign = out_free;
			rde_pkg::ST_EMIT:  load_digit = out_free;
			default: begin
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rde_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// Capture sign and magnitude; the negation of the most negative value wraps to 2^31.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= s_tdata[rde_pkg::NUM_W-1];
			mag_q <= s_tdata[rde_pkg::NUM_W-1] ? (~s_tdata + 1'b1) : s_tdata;
		end
	end

	// Digit stack: remainders pushed least significant first, popped for output.
	always_ff @(posedge clk) begin
		if (push)
			digit_q[sp_q[rde_pkg::STACK_IDX_W-1:0]] <= div_rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sp_q <= '0;
		else if (state_q == rde_pkg::ST_CHECK)
			sp_q <= '0;
		else if (push)
			sp_q <= sp_q + 1'b1;
		else if (load_digit)
			sp_q <= sp_m1;
	end

	// Output register parts the sequencer from the downstream stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (load_sign || load_digit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	// The top of the stack is read here and mapped through the alphabet.
	always_ff @(posedge clk) begin
		if (load_sign) begin
			m_tdata_q <= rde_pkg::SYM_MINUS;
			m_tlast_q <= 1'b0;
		end else if (load_digit) begin
			m_tdata_q <= alpha_q[digit_q[sp_m1[rde_pkg::STACK_IDX_W-1:0]][IDX_W-1:0]];
			m_tlast_q <= (sp_q == rde_pkg::STACK_CNT_W'(1));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// The stack is never popped empty.
	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rde_pkg::ST_EMIT) |-> (sp_q != '0))
		else $error("emit state with empty digit stack");

	// A finished division is only seen while the sequencer waits for it.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == rde_pkg::ST_DIV))
		else $error("divider completion outside division state");

	// A push never runs past the stack.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (sp_q < rde_pkg::STACK_CNT_W'(rde_pkg::STACK_DEPTH)))
		else $error("digit stack overflow");

	// The sign is never the final symbol.
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		load_sign |=> (m_tvalid && !m_tlast && m_tdata == rde_pkg::SYM_MINUS))
		else $error("sign symbol flagged as last");

endmodule

>>> sv/rde_div_unit.sv
// Shared iterative divider: 32-bit magnitude by a radix of at most 16.
// Depends on rde_pkg for widths and the status struct.
module rde_div_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rde_pkg::NUM_W-1:0]     dividend,
	input  logic [rde_pkg::BASE_W-1:0]    divisor,
	output logic [rde_pkg::NUM_W-1:0]     quotient,
	output logic [rde_pkg::DIGIT_W-1:0]   remainder,
	output rde_pkg::div_status_t          status
);

	logic [rde_pkg::NUM_W-1:0]     num_q;
	logic [rde_pkg::DIGIT_W-1:0]   rem_q;
	logic [rde_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [rde_pkg::NUM_W-1:0]     num_nxt;
	logic [rde_pkg::DIGIT_W-1:0]   rem_nxt;

	// Eight restoring steps per cycle; quotient bits shift in at the bottom.
	always_comb begin
		logic [rde_pkg::BASE_W-1:0] t;
		logic                       ge;
		num_nxt = num_q;
		rem_nxt = rem_q;
		for (int k = 0; k < rde_pkg::DIV_BITS_PER_STEP; k++) begin
			t       = {rem_nxt, num_nxt[rde_pkg::NUM_W-1]};
			ge      = (t >= divisor);
			t       = ge ? (t - divisor) : t;
			rem_nxt = t[rde_pkg::DIGIT_W-1:0];
			num_nxt = {num_nxt[rde_pkg::NUM_W-2:0], ge};
		end
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == rde_pkg::DIV_CNT_W'(rde_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Working operands.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign quotient    = num_q;
	assign remainder   = rem_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

>>> sv/rde_alpha_chk.sv
// Alphabet validity check over the stored symbols and the radix.
// Depends on rde_pkg for widths and fixed characters.
module rde_alpha_chk #(
	parameter int MAX_SYMBOLS = 16
) (
	input  logic [MAX_SYMBOLS-1:0][rde_pkg::SYM_W-1:0] alpha,
	input  logic [rde_pkg::BASE_W-1:0]                 base_length,
	output logic                                       ok
);

	localparam logic [rde_pkg::BASE_W-1:0] MAX_N = rde_pkg::BASE_W'(MAX_SYMBOLS);

	// Radix 2..MAX_SYMBOLS; symbols in use unique and not NUL/+/-.
	always_comb begin
		ok = (base_length >= rde_pkg::BASE_W'(2)) && (base_length <= MAX_N);
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			if (rde_pkg::BASE_W'(i) < base_length) begin
				if (alpha[i] == rde_pkg::SYM_NUL || alpha[i] == rde_pkg::SYM_PLUS ||
				    alpha[i] == rde_pkg::SYM_MINUS)
					ok = 1'b0;
				for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
					if (rde_pkg::BASE_W'(j) < base_length && alpha[j] == alpha[i])
						ok = 1'b0;
				end
			end
		end
	end

endmodule
